// ===== design/assert_macros.svh =====
// Assertion macros used by the pointer_murmur_hash128 pipeline module.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PMH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pointer_murmur_hash128: assertion failed");

// next-cycle implication
`define PMH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pointer_murmur_hash128: assertion failed");

// implication after a fixed number of cycles
`define PMH_ASSERT_LAT(lbl, ante, cons, n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("pointer_murmur_hash128: assertion failed");

`endif

// ===== design/pmh_pkg.sv =====
// Types and constants of the pointer hash pipeline.
// No dependencies; used by pmh_mul64, pointer_murmur_hash128 and its test.
package pmh_pkg;

    typedef logic [63:0] word_t;
    typedef logic [31:0] half_t;

    localparam word_t MUL_A = 64'h87c3_7b91_1142_53d5;
    localparam word_t MUL_B = 64'h4cf5_ad43_2745_937f;
    localparam word_t FIN_A = 64'hff51_afd7_ed55_8ccd;
    localparam word_t FIN_B = 64'hc4ce_b9fe_1a85_ec53;
    localparam word_t ADD_1 = 64'h0000_0000_52dc_e729;
    localparam word_t ADD_2 = 64'h0000_0000_3849_5ab5;

    // input register, four multiply pairs, six mixing stages, two final stages
    localparam int PIPE_DEPTH = 17;

    function automatic word_t rotl64(input word_t x, input int unsigned n);
        rotl64 = (x << n) | (x >> (7'd64 - 7'(n)));
    endfunction

    function automatic word_t xsh33(input word_t x);
        xsh33 = x ^ (x >> 33);
    endfunction

endpackage

// ===== design/pmh_mul64.sv =====
// Two-stage 64-bit by 64-bit multiplier keeping the low 64 bits of the product.
// Uses pmh_pkg types; three 32x32 partial products, then one summing stage.
module pmh_mul64 (
    input  logic          clk,
    input  pmh_pkg::word_t operand,
    input  pmh_pkg::word_t factor,
    output pmh_pkg::word_t product
);
    import pmh_pkg::*;

    word_t pp_lo_reg;
    half_t pp_hl_reg;
    half_t pp_lh_reg;
    word_t product_reg;

    word_t pp_lo_next;
    half_t pp_hl_next;
    half_t pp_lh_next;
    word_t product_next;

    always_comb
    begin
        pp_lo_next   = {32'b0, operand[31:0]} * {32'b0, factor[31:0]};
        pp_hl_next   = operand[63:32] * factor[31:0];
        pp_lh_next   = operand[31:0] * factor[63:32];
        product_next = pp_lo_reg + {pp_hl_reg + pp_lh_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg   <= pp_lo_next;
        pp_hl_reg   <= pp_hl_next;
        pp_lh_reg   <= pp_lh_next;
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== design/pointer_murmur_hash128.sv =====
// Top level of the 128-bit pointer hash pipeline (MurmurHash3 x64_128 style).
// Depends on pmh_pkg, pmh_mul64 and assert_macros.svh.
//
// Accepts one pointer on every cycle that start is high; busy is always low.
// Each result appears on hash_high_lane and hash_low_lane with done high for
// exactly one cycle, in input order. The pipeline is an input register, four
// 64-bit constant multiplies in series, each split into a partial-product
// stage and a summing stage, add/rotate mixing after the second multiply, and
// final add and output registers. Write hash_seed only while no item is in flight.
`include "assert_macros.svh"

module pointer_murmur_hash128 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hash_seed_wr,
    input  pmh_pkg::half_t hash_seed,
    input  logic           start,
    output logic           busy,
    input  pmh_pkg::word_t pointer_value,
    output logic           done,
    output pmh_pkg::word_t hash_high_lane,
    output pmh_pkg::word_t hash_low_lane
);
    import pmh_pkg::*;

    half_t                 hash_seed_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    word_t p_reg;
    word_t seed64;
    word_t t1_w;
    word_t t2_w;

    word_t m1_pa, m1_pb, m1_t1, m1_t2;
    word_t s1p, s2p, s1t, s2t;

    word_t ra_reg, s2p_c1_reg, s1t_c1_reg, s2t_c1_reg;
    word_t a1_reg, s2p_c2_reg, s1t_c2_reg, s2t_c2_reg;
    word_t rb_reg, a1_c3_reg, s1t_c3_reg, s2t_c3_reg;
    word_t b1_reg, a2_reg;
    word_t a3_reg, b1_c5_reg;
    word_t fa_reg, fb_reg;
    word_t ma, mb, na, nb;
    word_t a4_reg, xb_reg;
    word_t hash_high_lane_reg, hash_low_lane_reg;

    word_t ra_next, a1_next, rb_next, b1_next, a2_next, a3_next, b3_next;
    word_t fa_next, fb_next, xa_next, xb_next, a4_next;
    word_t hash_high_lane_next, hash_low_lane_next;

    assign busy     = 1'b0;
    assign seed64   = {32'b0, hash_seed_reg};
    assign t1_w     = {48'b0, p_reg[39:24]};
    assign t2_w     = {16'b0, p_reg[55:40], 16'b0};
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
            vld_reg       <= '0;
        end
        else
        begin
            if (hash_seed_wr)
            begin
                hash_seed_reg <= hash_seed;
            end
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            p_reg <= pointer_value;
        end
    end

    // first multiply of each scramble
    pmh_mul64 u_mul_pa (.clk(clk), .operand(p_reg), .factor(MUL_A), .product(m1_pa));
    pmh_mul64 u_mul_pb (.clk(clk), .operand(p_reg), .factor(MUL_B), .product(m1_pb));
    pmh_mul64 u_mul_t1 (.clk(clk), .operand(t1_w),  .factor(MUL_A), .product(m1_t1));
    pmh_mul64 u_mul_t2 (.clk(clk), .operand(t2_w),  .factor(MUL_B), .product(m1_t2));

    // rotate, then second multiply
    pmh_mul64 u_mul_s1p (.clk(clk), .operand(rotl64(m1_pa, 31)), .factor(MUL_B), .product(s1p));
    pmh_mul64 u_mul_s2p (.clk(clk), .operand(rotl64(m1_pb, 33)), .factor(MUL_A), .product(s2p));
    pmh_mul64 u_mul_s1t (.clk(clk), .operand(rotl64(m1_t1, 31)), .factor(MUL_B), .product(s1t));
    pmh_mul64 u_mul_s2t (.clk(clk), .operand(rotl64(m1_t2, 33)), .factor(MUL_A), .product(s2t));

    always_comb
    begin
        ra_next = rotl64(seed64 ^ s1p, 27) + seed64;
        a1_next = ra_reg + (ra_reg << 2) + ADD_1;
        rb_next = rotl64(seed64 ^ s2p_c2_reg, 31) + a1_reg;
        b1_next = (rb_reg + (rb_reg << 2) + ADD_2) ^ s2t_c3_reg;
        a2_next = a1_c3_reg ^ s1t_c3_reg;
        a3_next = a2_reg + b1_reg;
        b3_next = b1_c5_reg + a3_reg;
        fa_next = xsh33(a3_reg);
        fb_next = xsh33(b3_next);
    end

    // mixing stages
    always_ff @(posedge clk)
    begin
        ra_reg     <= ra_next;
        s2p_c1_reg <= s2p;
        s1t_c1_reg <= s1t;
        s2t_c1_reg <= s2t;

        a1_reg     <= a1_next;
        s2p_c2_reg <= s2p_c1_reg;
        s1t_c2_reg <= s1t_c1_reg;
        s2t_c2_reg <= s2t_c1_reg;

        rb_reg     <= rb_next;
        a1_c3_reg  <= a1_reg;
        s1t_c3_reg <= s1t_c2_reg;
        s2t_c3_reg <= s2t_c2_reg;

        b1_reg     <= b1_next;
        a2_reg     <= a2_next;

        a3_reg     <= a3_next;
        b1_c5_reg  <= b1_reg;

        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
    end

    // fmix64 on both halves
    pmh_mul64 u_mul_fa (.clk(clk), .operand(fa_reg),    .factor(FIN_A), .product(ma));
    pmh_mul64 u_mul_fb (.clk(clk), .operand(fb_reg),    .factor(FIN_A), .product(mb));
    pmh_mul64 u_mul_na (.clk(clk), .operand(xsh33(ma)), .factor(FIN_B), .product(na));
    pmh_mul64 u_mul_nb (.clk(clk), .operand(xsh33(mb)), .factor(FIN_B), .product(nb));

    always_comb
    begin
        xa_next             = xsh33(na);
        xb_next             = xsh33(nb);
        a4_next             = xa_next + xb_next;
        hash_high_lane_next = a4_reg;
        hash_low_lane_next  = xb_reg + a4_reg;
    end

    always_ff @(posedge clk)
    begin
        a4_reg <= a4_next;
        xb_reg <= xb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_high_lane_reg <= '0;
            hash_low_lane_reg  <= '0;
        end
        else if (vld_reg[PIPE_DEPTH-2])
        begin
            hash_high_lane_reg <= hash_high_lane_next;
            hash_low_lane_reg  <= hash_low_lane_next;
        end
    end

    assign done           = vld_reg[PIPE_DEPTH-1];
    assign hash_high_lane = hash_high_lane_reg;
    assign hash_low_lane  = hash_low_lane_reg;

    `PMH_ASSERT_LAT(a_item_delivered, start && !busy, done, PIPE_DEPTH)
    `PMH_ASSERT_IMP(a_no_phantom_result, done, $past(start, PIPE_DEPTH))
    `PMH_ASSERT_NXT(a_result_hold, !vld_reg[PIPE_DEPTH-2], $stable({hash_high_lane, hash_low_lane}))

endmodule

// ===== verif/pointer_murmur_hash128_test.sv =====
// Self-checking test of pointer_murmur_hash128: directed corner pointers, then
// random pointers under several seeds, checked against an in-bench hash model.
// Depends on pmh_pkg (port types, pipeline depth) and the DUT itself.
module pointer_murmur_hash128_test;

    typedef pmh_pkg::word_t word_t;
    typedef pmh_pkg::half_t half_t;

    typedef struct {
        word_t high_lane;
        word_t low_lane;
    } hash_pair_t;

    localparam word_t K_MIX1 = 64'h87c3_7b91_1142_53d5;
    localparam word_t K_MIX2 = 64'h4cf5_ad43_2745_937f;
    localparam word_t K_FIN1 = 64'hff51_afd7_ed55_8ccd;
    localparam word_t K_FIN2 = 64'hc4ce_b9fe_1a85_ec53;
    localparam word_t K_ADD1 = 64'h0000_0000_52dc_e729;
    localparam word_t K_ADD2 = 64'h0000_0000_3849_5ab5;

    localparam int LATENCY     = pmh_pkg::PIPE_DEPTH;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    class hash_scoreboard;
        half_t      seed;
        hash_pair_t pending_hashes[$];
        int         errors;

        function new();
            seed   = '0;
            errors = 0;
        endfunction

        static function word_t rotl(input word_t v, input int unsigned n);
            return (v << n) | (v >> (64 - n));
        endfunction

        static function word_t fmix(input word_t v);
            word_t m;
            m = v ^ (v >> 33);
            m = m * K_FIN1;
            m = m ^ (m >> 33);
            m = m * K_FIN2;
            m = m ^ (m >> 33);
            return m;
        endfunction

        static function word_t scramble_a(input word_t w);
            return rotl(w * K_MIX1, 31) * K_MIX2;
        endfunction

        static function word_t scramble_b(input word_t w);
            return rotl(w * K_MIX2, 33) * K_MIX1;
        endfunction

        function hash_pair_t hash_of_pointer(input word_t p);
            hash_pair_t r;
            word_t      h1;
            word_t      h2;
            word_t      tail1;
            word_t      tail2;
            h1 = {32'h0, seed};
            h2 = {32'h0, seed};
            h1 = h1 ^ scramble_a(p);
            h1 = rotl(h1, 27) + h2;
            h1 = h1 * 64'd5 + K_ADD1;
            h2 = h2 ^ scramble_b(p);
            h2 = rotl(h2, 31) + h1;
            h2 = h2 * 64'd5 + K_ADD2;
            tail2 = {32'h0, p[55:48], p[47:40], 16'h0};
            h2 = h2 ^ scramble_b(tail2);
            tail1 = {48'h0, p[39:32], p[31:24]};
            h1 = h1 ^ scramble_a(tail1);
            h1 = h1 + h2;
            h2 = h2 + h1;
            h1 = fmix(h1);
            h2 = fmix(h2);
            h1 = h1 + h2;
            h2 = h2 + h1;
            r.high_lane = h1;
            r.low_lane  = h2;
            return r;
        endfunction

        function void set_seed(input half_t s);
            seed = s;
        endfunction

        function void note_pointer(input word_t p);
            pending_hashes.push_back(hash_of_pointer(p));
        endfunction

        function void check_hash(input word_t high_lane, input word_t low_lane);
            hash_pair_t exp_pair;
            if (pending_hashes.size() == 0)
            begin
                $error("unexpected result: hash_high_lane %h hash_low_lane %h",
                       high_lane, low_lane);
                errors++;
                return;
            end
            exp_pair = pending_hashes.pop_front();
            if (high_lane !== exp_pair.high_lane)
            begin
                $error("hash_high_lane mismatch: expected %h, actual %h",
                       exp_pair.high_lane, high_lane);
                errors++;
            end
            if (low_lane !== exp_pair.low_lane)
            begin
                $error("hash_low_lane mismatch: expected %h, actual %h",
                       exp_pair.low_lane, low_lane);
                errors++;
            end
        endfunction

        function int pending();
            return pending_hashes.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  hash_seed_wr;
    half_t hash_seed;
    logic  start;
    logic  busy;
    word_t pointer_value;
    logic  done;
    word_t hash_high_lane;
    word_t hash_low_lane;

    hash_scoreboard sb;
    int             quiet_cycles;

    pointer_murmur_hash128 dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .hash_seed_wr   (hash_seed_wr),
        .hash_seed      (hash_seed),
        .start          (start),
        .busy           (busy),
        .pointer_value  (pointer_value),
        .done           (done),
        .hash_high_lane (hash_high_lane),
        .hash_low_lane  (hash_low_lane)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pointer(pointer_value);
            if (done)
                sb.check_hash(hash_high_lane, hash_low_lane);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic word_t random_pointer();
        logic [31:0] r0;
        logic [31:0] r1;
        int          mode;
        r0   = $urandom;
        r1   = $urandom;
        mode = $urandom_range(0, 9);
        case (mode)
            5:       return {16'h0000, 1'b0, r1[14:0], r0[31:3], 3'b000};
            6:       return {16'hffff, 1'b1, r1[14:0], r0[31:3], 3'b000};
            7:       return {8'h00, r0, 24'h00_0000};
            8:       return 64'h1 << $urandom_range(0, 63);
            9:       return ~(64'h1 << $urandom_range(0, 63));
            default: return {r1, r0};
        endcase
    endfunction

    // hold start until the item is taken, then advance to the next falling edge
    task automatic send_pointer(input word_t p);
        start         = 1'b1;
        pointer_value = p;
        hash_seed     = $urandom;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        start = 1'b0;
        repeat (n)
        begin
            pointer_value = {$urandom, $urandom};
            hash_seed     = $urandom;
            @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_seed(input half_t s);
        hash_seed_wr = 1'b1;
        hash_seed    = s;
        @(negedge clk);
        hash_seed_wr = 1'b0;
        sb.set_seed(s);
    endtask

    initial
    begin
        half_t next_seed;
        bit    quiet;
        sb            = new();
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        hash_seed_wr  = 1'b0;
        hash_seed     = '0;
        start         = 1'b0;
        pointer_value = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset seed, corner pointers
        send_pointer(64'h0000_0000_0000_0000);
        send_pointer(64'hffff_ffff_ffff_ffff);
        send_pointer(64'h0000_0000_0000_0001);
        send_pointer(64'h8000_0000_0000_0000);
        idle_for(3);
        send_pointer(64'h0000_0000_ff00_0000);
        send_pointer(64'h0000_00ff_0000_0000);
        send_pointer(64'h0000_ff00_0000_0000);
        send_pointer(64'h00ff_0000_0000_0000);
        send_pointer(64'h00ff_ffff_ff00_0000);
        send_pointer(64'hff00_0000_00ff_ffff);
        idle_for(1);
        send_pointer(64'h0000_0000_00ff_ffff);
        send_pointer(64'hff00_0000_0000_0000);
        send_pointer(64'haaaa_aaaa_aaaa_aaaa);
        send_pointer(64'h5555_5555_5555_5555);
        idle_for(17);
        send_pointer(64'h0000_7fff_ffff_f000);
        send_pointer(64'hffff_8000_0000_0000);
        send_pointer(64'h0123_4567_89ab_cdef);
        send_pointer(64'hfedc_ba98_7654_3210);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       next_seed = 32'hffff_ffff;
                2:       next_seed = 32'h0000_0001;
                3:       next_seed = 32'h8000_0000;
                6:       next_seed = 32'h0000_0000;
                default: next_seed = $urandom;
            endcase
            wait_for_results();
            write_seed(next_seed);
            quiet = (phase == PHASES - 1);
            repeat (PHASE_ITEMS)
            begin
                send_pointer(random_pointer());
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 17));
            end
        end

        wait_for_results();
        repeat (2 * LATENCY) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
